// File: sv/aes128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes128_pkg;

    typedef logic [127:0] t_block;

    localparam int NumRounds = 10;

    localparam logic [7:0] RedPoly = 8'h1B;

    typedef enum logic {
        FUNC_ENC = 1'b0,
        FUNC_DEC = 1'b1
    } t_func;

    typedef enum logic {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // Byte i of a block sits at bits 127-8i .. 120-8i.
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? RedPoly : 8'h00);
    endfunction

    function automatic t_block sub_bytes(input t_block s, input logic inv);
        t_block o;
        o = '0;
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
        end
        return o;
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic inv);
        t_block o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = get_byte(s, 4 * c + r);
                end else begin
                    o[127 - 8 * (4 * c + r) -: 8] = get_byte(s, 4 * ((c + r) % 4) + r);
                end
            end
        end
        return o;
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic inv);
        t_block o;
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m1 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] acc;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_byte(s, 4 * c + r);
                a2[r] = xt(a[r]);
                a4[r] = xt(a2[r]);
                a8[r] = xt(a4[r]);
                m1[r] = a[r];
                m2[r] = a2[r];
                m3[r] = a2[r] ^ a[r];
                m9[r] = a8[r] ^ a[r];
                mb[r] = a8[r] ^ a2[r] ^ a[r];
                md[r] = a8[r] ^ a4[r] ^ a[r];
                me[r] = a8[r] ^ a4[r] ^ a2[r];
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    acc = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
                end else begin
                    acc = m2[r] ^ m3[(r + 1) % 4] ^ m1[(r + 2) % 4] ^ m1[(r + 3) % 4];
                end
                o[127 - 8 * (4 * c + r) -: 8] = acc;
            end
        end
        return o;
    endfunction

    function automatic t_block key_fwd(input t_block k, input logic [7:0] rc);
        t_block o;
        logic [31:0] w [4];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        o = {w[0], w[1], w[2], w[3]};
        return o;
    endfunction

    function automatic t_block key_bwd(input t_block k, input logic [7:0] rc);
        t_block o;
        logic [31:0] w [4];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
        w[3] = w[3] ^ w[2];
        w[2] = w[2] ^ w[1];
        w[1] = w[1] ^ w[0];
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        o = {w[0], w[1], w[2], w[3]};
        return o;
    endfunction

endpackage
`default_nettype wire

// File: sv/aes128_block_cipher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// AES-128 block cipher, fully pipelined, one round per stage.
//
// Channels:
//   i_s_axis_*  : input block. tdata = {block_low, block_high}, tuser = func
//                 (0 encrypt, 1 decrypt).
//   o_m_axis_*  : result block. tdata = {result_low, result_high}.
//   cfg write   : i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data.
//                 Index 0 writes key_high, index 1 writes key_low.
//                 For decryption the key registers hold round key 10.
// Path: the initial key add sits in front of round one, and each round has
// its own stage register; the last stage register is the output register.
// Throughput: one block per cycle; the ten round stages move together and
// all advance while the output register is free or being drained.
// Stall: when the output is full and the receiver holds tready low the whole
// pipeline holds and o_s_axis_tready drops; nothing is lost.
// Reset clears the key registers to zero and every stage valid bit.
module aes128_block_cipher_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // [63:0] block_high, [127:64] block_low
    input  wire logic         i_s_axis_tuser,  // [0] func
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [127:0]      o_m_axis_tdata,  // [63:0] result_high, [127:64] result_low
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import aes128_pkg::*;

    localparam int Stages = NumRounds;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;

    logic         r_vld [Stages];
    logic         r_dec [Stages];
    t_block       r_st  [Stages];
    t_block       r_key [Stages];

    logic   advance;
    t_block in_blk;
    t_block cfg_key;

    assign o_cfg_ready = 1'b1;
    // Whole pipeline moves when the last stage can hand off.
    assign advance         = !r_vld[Stages-1] || i_m_axis_tready;
    assign o_s_axis_tready = advance;
    assign o_m_axis_tvalid = r_vld[Stages-1];
    assign o_m_axis_tdata  = {r_st[Stages-1][63:0], r_st[Stages-1][127:64]};

    assign in_blk  = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
    assign cfg_key = {r_key_high, r_key_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage s holds the state after round s+1 (encrypt) or after the
    // inverse round with key index 9-s (decrypt), together with that key.
    for (genvar s = 0; s < Stages; s++) begin : g_round
        t_block src_st;
        t_block src_key;
        logic   src_dec;
        logic   src_vld;
        t_block n_key;
        t_block n_st;
        t_block t_sub;

        if (s == 0) begin : g_first
            assign src_st  = in_blk ^ cfg_key;
            assign src_key = cfg_key;
            assign src_dec = i_s_axis_tuser;
            assign src_vld = i_s_axis_tvalid;
        end else begin : g_next
            assign src_st  = r_st[s-1];
            assign src_key = r_key[s-1];
            assign src_dec = r_dec[s-1];
            assign src_vld = r_vld[s-1];
        end

        always_comb begin
            if (src_dec == FUNC_DEC) begin
                n_key = key_bwd(src_key, RCON[Stages-1-s]);
                t_sub = sub_bytes(shift_rows(src_st, 1'b1), 1'b1) ^ n_key;
                n_st  = (s == Stages - 1) ? t_sub : mix_columns(t_sub, 1'b1);
            end else begin
                n_key = key_fwd(src_key, RCON[s]);
                t_sub = shift_rows(sub_bytes(src_st, 1'b0), 1'b0);
                n_st  = ((s == Stages - 1) ? t_sub : mix_columns(t_sub, 1'b0)) ^ n_key;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (advance) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_st[s]  <= n_st;
                r_key[s] <= n_key;
                r_dec[s] <= src_dec;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/aes128_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module aes128_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [127:0] o_m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind aes128_block_cipher_top aes128_checker u_aes128_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
